/* hdl/ansi_escape_renderer_core_assert.svh */
// Assertion macros for the escape renderer core
`ifndef ANSI_ESCAPE_RENDERER_CORE_ASSERT_SVH
`define ANSI_ESCAPE_RENDERER_CORE_ASSERT_SVH
`define AER_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define AER_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* hdl/aer_pkg.sv */
// Package: request and result types and constants for the escape renderer
package aer_pkg;
    localparam int MaxArgsDefault = 16;
    localparam logic [7:0] EscChar = 8'h1B;
    localparam logic [2:0] KindGlyph = 3'd0;
    localparam logic [2:0] KindMove = 3'd1;
    localparam logic [2:0] KindMoveLs = 3'd2;
    localparam logic [2:0] KindLsRight = 3'd3;
    localparam logic [2:0] KindSetPos = 3'd4;
    localparam logic CfgDefFg = 1'b0;
    localparam logic CfgDefBg = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic [3:0]  palette_index;
        logic [23:0] palette_rgb;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  glyph_code;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic [1:0]  weight;
        logic        italic;
        logic [1:0]  underline;
        logic        strike;
        logic [1:0]  direction;
        logic [7:0]  arg_a;
        logic [7:0]  arg_b;
    } t_out;

    function automatic logic [7:0] cube_level(input logic [2:0] idx);
        cube_level = (idx == 3'd0) ? 8'd0 : 8'(8'd55 + 8'(idx) * 8'd40);
    endfunction

    function automatic logic [23:0] cube_rgb(input logic [7:0] k);
        logic [2:0] r;
        logic [2:0] g;
        logic [2:0] b;
        logic [7:0] rem;
        r = 3'(k >= 8'd36) + 3'(k >= 8'd72) + 3'(k >= 8'd108) + 3'(k >= 8'd144)
            + 3'(k >= 8'd180);
        rem = k - 8'(r) * 8'd36;
        g = 3'(rem >= 8'd6) + 3'(rem >= 8'd12) + 3'(rem >= 8'd18) + 3'(rem >= 8'd24)
            + 3'(rem >= 8'd30);
        b = 3'(rem - 8'(g) * 8'd6);
        cube_rgb = {cube_level(r), cube_level(g), cube_level(b)};
    endfunction
endpackage

/* hdl/ansi_escape_renderer_core.sv */
// Top level: ANSI CSI/SGR escape parser driving a glyph and cursor command stream
// Usage:
//  Input channel i_in_valid/o_in_stall carries t_in requests: text characters or
//  base palette writes. Output channel o_out_valid/i_out_stall carries t_out
//  results: glyphs with attributes or cursor commands; at most one per request.
//  Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) set default colours;
//  the user must issue them only while the block is idle; the block does not enforce it.
//  Sequence: a text or palette request is accepted, then decoded; its
//  result shows in the output register the cycle after decode. An SGR final
//  byte walks the stored argument list one argument per cycle through one
//  shared colour/code unit, and new requests wait until the walk ends.
//  Argument memory is read one address per cycle.
//  Reset clears parser, attributes and palette; colours take the defaults.
//  While the receiver stalls, the result is held and new requests wait once
//  the output register is full.
module ansi_escape_renderer_core
    import aer_pkg::*;
#(
    parameter int MAX_ARGS = MaxArgsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    `include "ansi_escape_renderer_core_assert.svh"

    localparam int AW = $clog2(MAX_ARGS);
    localparam int CW = $clog2(MAX_ARGS + 1);

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_SGR, S_MODE, S_COL, S_RGB} t_state;

    t_state r_state;
    t_in r_req;
    logic [1:0] r_mode;
    logic [7:0] r_acc;
    logic r_pres;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [7:0] r_args [MAX_ARGS];
    logic [7:0] r_rd;
    logic [7:0] r_a0;
    logic [7:0] r_a1;
    logic [23:0] r_fg, r_bg, r_dfg, r_dbg;
    logic [1:0] r_wt, r_ul;
    logic r_it, r_st, r_sw;
    logic [23:0] r_pal [16];
    logic r_selbg;
    logic [1:0] r_rgbn;
    logic [15:0] r_rgbacc;
    logic r_ov;
    t_out r_out;

    logic [7:0] c;
    logic push, wr_en;
    logic [CW-1:0] cnt_p;
    logic [AW-1:0] rd_addr;
    assign c = r_req.char_code;
    assign push = r_pres && (r_cnt < CW'(MAX_ARGS));
    assign cnt_p = push ? r_cnt + 1'b1 : r_cnt;
    assign o_in_stall = (r_state != S_IDLE) || (r_ov && i_out_stall);
    assign o_out_valid = r_ov;
    assign o_out = r_out;

    function automatic logic [23:0] color_of(input logic [7:0] n, input logic [23:0] pe);
        logic [7:0] g;
        g = 8'((n - 8'd232) * 8'd10 + 8'd8);
        if (n < 8'd16) color_of = pe;
        else if (n < 8'd232) color_of = cube_rgb(n - 8'd16);
        else color_of = {g, g, g};
    endfunction

    logic [7:0] col_n;
    logic [7:0] a;
    logic [23:0] col;
    always_comb begin
        a = r_rd;
        col_n = 8'd0;
        if (r_state == S_COL) col_n = a;
        else if (a >= 8'd30 && a < 8'd38) col_n = a - 8'd30;
        else if (a >= 8'd40 && a < 8'd48) col_n = a - 8'd40;
        else if (a >= 8'd90 && a < 8'd98) col_n = a - 8'd82;
        else if (a >= 8'd100 && a < 8'd108) col_n = a - 8'd92;
        col = color_of(col_n, r_pal[col_n[3:0]]);
    end

    logic [7:0] arg0;
    logic [7:0] arg1;
    t_out n_out;
    logic n_ov;
    logic n_sgr;
    always_comb begin
        n_out = '0;
        n_ov = 1'b0;
        n_sgr = 1'b0;
        arg0 = (push && r_cnt == '0) ? r_acc : r_a0;
        arg1 = (push && r_cnt == CW'(1)) ? r_acc : r_a1;
        if (r_req.req_type || r_mode == 2'd1) begin
            n_ov = 1'b0;
        end else if (r_mode == 2'd2) begin
            if (!(c >= "0" && c <= "9") && !(c == " " || c == ";")) begin
                if (c == "m") begin
                    n_sgr = (cnt_p != '0);
                end else if (c >= "A" && c <= "G") begin
                    n_ov = 1'b1;
                    n_out.arg_a = (cnt_p == '0) ? 8'd1 : arg0;
                    case (c)
                        "A": begin n_out.out_kind = KindMove; n_out.direction = 2'd0; end
                        "B": begin n_out.out_kind = KindMove; n_out.direction = 2'd1; end
                        "C": begin n_out.out_kind = KindMove; n_out.direction = 2'd2; end
                        "D": begin n_out.out_kind = KindMove; n_out.direction = 2'd3; end
                        "E": begin n_out.out_kind = KindMoveLs; n_out.direction = 2'd1; end
                        "F": begin n_out.out_kind = KindMoveLs; n_out.direction = 2'd0; end
                        default: begin
                            n_out.out_kind = KindLsRight;
                            n_out.direction = 2'd2;
                        end
                    endcase
                end else if ((c == "H" || c == "f") && cnt_p > CW'(1)) begin
                    n_ov = 1'b1;
                    n_out.out_kind = KindSetPos;
                    n_out.arg_a = arg0;
                    n_out.arg_b = arg1;
                end
            end
        end else if (c != EscChar) begin
            n_ov = 1'b1;
            n_out.out_kind = KindGlyph;
            n_out.glyph_code = c;
            n_out.fg_rgb = r_fg;
            n_out.bg_rgb = r_bg;
            n_out.weight = r_wt;
            n_out.italic = r_it;
            n_out.underline = r_ul;
            n_out.strike = r_st;
        end
    end

    assign wr_en = (r_state == S_DEC) && !r_req.req_type && (r_mode == 2'd2)
        && !(c >= "0" && c <= "9") && push;
    always_comb begin
        rd_addr = AW'(r_i);
        if (r_state == S_DEC) rd_addr = '0;
        else if (r_state != S_IDLE) rd_addr = AW'(r_i + 1'b1);
    end
    always_ff @(posedge i_clk) begin
        if (wr_en) r_args[AW'(r_cnt)] <= r_acc;
        r_rd <= (wr_en && AW'(r_cnt) == rd_addr) ? r_acc : r_args[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= 2'd0;
            r_acc <= '0;
            r_pres <= 1'b0;
            r_cnt <= '0;
            r_i <= '0;
            r_dfg <= 24'h000000;
            r_dbg <= 24'hFFFFFF;
            r_fg <= 24'h000000;
            r_bg <= 24'hFFFFFF;
            r_wt <= '0; r_ul <= '0; r_it <= 1'b0; r_st <= 1'b0; r_sw <= 1'b0;
            for (int k = 0; k < 16; k++) r_pal[k] <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgDefFg) r_dfg <= i_cfg_data;
                else r_dbg <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_req <= i_in;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= n_sgr ? S_SGR : S_IDLE;
                    r_out <= n_out;
                    if (n_ov) r_ov <= 1'b1;
                    if (r_req.req_type) begin
                        r_pal[r_req.palette_index] <= r_req.palette_rgb;
                    end else if (r_mode == 2'd1) begin
                        r_mode <= (c == "[") ? 2'd2 : 2'd0;
                        r_cnt <= '0; r_acc <= '0; r_pres <= 1'b0;
                    end else if (r_mode == 2'd2) begin
                        if (c >= "0" && c <= "9") begin
                            r_acc <= 8'(r_acc * 8'd10 + (c - "0"));
                            r_pres <= 1'b1;
                        end else begin
                            r_cnt <= cnt_p;
                            r_acc <= '0;
                            r_pres <= 1'b0;
                            if (push && r_cnt == '0) r_a0 <= r_acc;
                            if (push && r_cnt == CW'(1)) r_a1 <= r_acc;
                            if (!(c == " " || c == ";")) begin
                                r_mode <= 2'd0;
                                r_i <= '0;
                            end
                        end
                    end else if (c == EscChar) begin
                        r_mode <= 2'd1;
                    end
                end
                S_SGR: begin
                    r_i <= r_i + 1'b1;
                    if (a == 8'd38 || a == 8'd48) begin
                        r_state <= (r_i + 1'b1 >= r_cnt) ? S_IDLE : S_MODE;
                    end else if (r_i + 1'b1 >= r_cnt) begin
                        r_state <= S_IDLE;
                    end
                    case (a)
                        8'd0: begin
                            r_fg <= r_dfg; r_bg <= r_dbg;
                            r_wt <= '0; r_it <= 1'b0; r_ul <= '0; r_st <= 1'b0;
                        end
                        8'd1: r_wt <= 2'd1;
                        8'd2: r_wt <= 2'd2;
                        8'd3: r_it <= 1'b1;
                        8'd4: r_ul <= 2'd1;
                        8'd7: if (!r_sw) begin r_fg <= r_bg; r_bg <= r_fg; r_sw <= 1'b1; end
                        8'd9: r_st <= 1'b1;
                        8'd21: r_ul <= 2'd2;
                        8'd22: r_wt <= '0;
                        8'd23: r_it <= 1'b0;
                        8'd24: r_ul <= '0;
                        8'd27: if (r_sw) begin r_fg <= r_bg; r_bg <= r_fg; r_sw <= 1'b0; end
                        8'd29: r_st <= 1'b0;
                        8'd38, 8'd48: r_selbg <= (a == 8'd48);
                        8'd39: r_fg <= r_dfg;
                        8'd49: r_bg <= r_dbg;
                        default: begin
                            if ((a >= 8'd30 && a < 8'd38) || (a >= 8'd90 && a < 8'd98))
                                r_fg <= col;
                            else if ((a >= 8'd40 && a < 8'd48) || (a >= 8'd100 && a < 8'd108))
                                r_bg <= col;
                        end
                    endcase
                end
                S_MODE: begin
                    r_i <= r_i + 1'b1;
                    r_rgbn <= '0;
                    if (a == 8'd5) begin
                        r_state <= (r_i + 1'b1 >= r_cnt) ? S_IDLE : S_COL;
                    end else if (a == 8'd2) begin
                        r_state <= (r_cnt - (r_i + 1'b1) < CW'(3)) ? S_IDLE : S_RGB;
                    end else begin
                        r_state <= (r_i + 1'b1 >= r_cnt) ? S_IDLE : S_SGR;
                    end
                end
                S_COL: begin
                    r_i <= r_i + 1'b1;
                    if (r_selbg) r_bg <= col; else r_fg <= col;
                    r_state <= (r_i + 1'b1 >= r_cnt) ? S_IDLE : S_SGR;
                end
                S_RGB: begin
                    r_i <= r_i + 1'b1;
                    r_rgbn <= r_rgbn + 1'b1;
                    r_rgbacc <= {r_rgbacc[7:0], a};
                    if (r_rgbn == 2'd2) begin
                        if (r_selbg) r_bg <= {r_rgbacc, a}; else r_fg <= {r_rgbacc, a};
                        r_state <= (r_i + 1'b1 >= r_cnt) ? S_IDLE : S_SGR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AER_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `AER_ASSERT_NXT(a_accept_dec, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_DEC)
    `AER_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out))
    `AER_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_ARGS))
endmodule

/* bench/tb.sv */
// Testbench for the escape renderer core: directed and random character streams vs a predictor
module tb;
    import aer_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumArgs = MaxArgsDefault;
    localparam int CycleLimit = 1500000;
    localparam int RandomItems = 1450;

    class render_scoreboard;
        t_out        glyph_q[$];
        int          errors;
        int          matched;
        logic [23:0] def_fg;
        logic [23:0] def_bg;
        logic [1:0]  mode;
        logic [7:0]  accum;
        bit          have_digit;
        logic [7:0]  args[NumArgs];
        int          argc;
        logic [23:0] fg;
        logic [23:0] bg;
        logic [1:0]  weight;
        logic        italic;
        logic [1:0]  underline;
        logic        strike;
        bit          reversed;
        logic [23:0] palette[16];

        function new();
            def_fg = 24'h000000;
            def_bg = 24'hFFFFFF;
            mode = 2'd0;
            accum = 8'd0;
            have_digit = 0;
            argc = 0;
            fg = def_fg;
            bg = def_bg;
            weight = 2'd0;
            italic = 1'b0;
            underline = 2'd0;
            strike = 1'b0;
            reversed = 0;
            errors = 0;
            matched = 0;
            foreach (palette[i]) palette[i] = 24'd0;
            foreach (args[i]) args[i] = 8'd0;
        endfunction

        function void set_default(logic idx, logic [23:0] v);
            if (idx == CfgDefFg) def_fg = v;
            else def_bg = v;
        endfunction

        function logic [7:0] level(int idx);
            return (idx == 0) ? 8'd0 : 8'(55 + idx * 40);
        endfunction

        function logic [23:0] colour(int n);
            int k;
            logic [7:0] g;
            if (n < 16) return palette[n];
            if (n < 232) begin
                k = n - 16;
                return {level(k / 36), level((k % 36) / 6), level(k % 6)};
            end
            g = 8'((n - 232) * 10 + 8);
            return {g, g, g};
        endfunction

        function void set_colour(bit to_bg, logic [23:0] v);
            if (to_bg) bg = v;
            else fg = v;
        endfunction

        function void swap_colours();
            logic [23:0] t;
            t = fg;
            fg = bg;
            bg = t;
        endfunction

        function void apply_attrs();
            int i;
            int a;
            int m;
            bit to_bg;
            i = 0;
            while (i < argc) begin
                a = args[i];
                i++;
                case (a)
                    0: begin
                        fg = def_fg; bg = def_bg;
                        weight = 0; italic = 0; underline = 0; strike = 0;
                    end
                    1: weight = 2'd1;
                    2: weight = 2'd2;
                    3: italic = 1'b1;
                    4: underline = 2'd1;
                    7: if (!reversed) begin swap_colours(); reversed = 1; end
                    9: strike = 1'b1;
                    21: underline = 2'd2;
                    22: weight = 2'd0;
                    23: italic = 1'b0;
                    24: underline = 2'd0;
                    27: if (reversed) begin swap_colours(); reversed = 0; end
                    29: strike = 1'b0;
                    38, 48: begin
                        to_bg = (a == 48);
                        if (i >= argc) return;
                        m = args[i];
                        i++;
                        if (m == 5) begin
                            if (i >= argc) return;
                            set_colour(to_bg, colour(args[i]));
                            i++;
                        end else if (m == 2) begin
                            if (argc - i < 3) return;
                            set_colour(to_bg, {args[i], args[i + 1], args[i + 2]});
                            i += 3;
                        end
                    end
                    39: fg = def_fg;
                    49: bg = def_bg;
                    default: begin
                        if (a >= 30 && a < 38) set_colour(0, colour(a - 30));
                        else if (a >= 40 && a < 48) set_colour(1, colour(a - 40));
                        else if (a >= 90 && a < 98) set_colour(0, colour(a - 82));
                        else if (a >= 100 && a < 108) set_colour(1, colour(a - 92));
                    end
                endcase
            end
        endfunction

        function void note_request(t_in r);
            t_out o;
            logic [7:0] c;
            o = '0;
            c = r.char_code;
            if (r.req_type) begin
                palette[r.palette_index] = r.palette_rgb;
                return;
            end
            if (mode == 2'd1) begin
                if (c == "[") begin
                    mode = 2'd2; argc = 0; accum = 0; have_digit = 0;
                end else begin
                    mode = 2'd0;
                end
                return;
            end
            if (mode == 2'd2) begin
                if (c >= "0" && c <= "9") begin
                    accum = 8'(accum * 10 + (c - "0"));
                    have_digit = 1;
                    return;
                end
                if (have_digit && argc < NumArgs) begin
                    args[argc] = accum;
                    argc++;
                end
                accum = 0;
                have_digit = 0;
                if (c == " " || c == ";") return;
                mode = 2'd0;
                o.arg_a = (argc > 0) ? args[0] : 8'd1;
                case (c)
                    "A": begin o.out_kind = KindMove; o.direction = 2'd0; end
                    "B": begin o.out_kind = KindMove; o.direction = 2'd1; end
                    "C": begin o.out_kind = KindMove; o.direction = 2'd2; end
                    "D": begin o.out_kind = KindMove; o.direction = 2'd3; end
                    "E": begin o.out_kind = KindMoveLs; o.direction = 2'd1; end
                    "F": begin o.out_kind = KindMoveLs; o.direction = 2'd0; end
                    "G": begin o.out_kind = KindLsRight; o.direction = 2'd2; end
                    "H", "f": begin
                        if (argc < 2) return;
                        o.out_kind = KindSetPos;
                        o.arg_a = args[0];
                        o.arg_b = args[1];
                    end
                    "m": begin apply_attrs(); return; end
                    default: return;
                endcase
                glyph_q.push_back(o);
                return;
            end
            if (c == EscChar) begin
                mode = 2'd1;
                return;
            end
            o.out_kind = KindGlyph;
            o.glyph_code = c;
            o.fg_rgb = fg;
            o.bg_rgb = bg;
            o.weight = weight;
            o.italic = italic;
            o.underline = underline;
            o.strike = strike;
            glyph_q.push_back(o);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task cmp(string name, logic [23:0] got, logic [23:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(t_out got);
            t_out w;
            if (glyph_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            w = glyph_q.pop_front();
            matched++;
            cmp("out_kind", 24'(got.out_kind), 24'(w.out_kind));
            cmp("glyph_code", 24'(got.glyph_code), 24'(w.glyph_code));
            cmp("fg_rgb", got.fg_rgb, w.fg_rgb);
            cmp("bg_rgb", got.bg_rgb, w.bg_rgb);
            cmp("weight", 24'(got.weight), 24'(w.weight));
            cmp("italic", 24'(got.italic), 24'(w.italic));
            cmp("underline", 24'(got.underline), 24'(w.underline));
            cmp("strike", 24'(got.strike), 24'(w.strike));
            cmp("direction", 24'(got.direction), 24'(w.direction));
            cmp("arg_a", 24'(got.arg_a), 24'(w.arg_a));
            cmp("arg_b", 24'(got.arg_b), 24'(w.arg_b));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [23:0] i_cfg_data = 24'd0;

    render_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 0;
    int  stall_left = 0;

    ansi_escape_renderer_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function int draw_wait();
        if (calm || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out);
            stall_left = draw_wait();
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task send(t_in r);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
        sent++;
    endtask

    task send_char(logic [7:0] c);
        t_in r;
        r = {1'b0, c, 4'($urandom), 24'($urandom)};
        send(r);
    endtask

    task send_palette(logic [3:0] idx, logic [23:0] rgb);
        send({1'b1, 8'($urandom), idx, rgb});
    endtask

    task send_text(string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    task drain();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.glyph_q.size() != 0) @(posedge i_clk);
        repeat (NumArgs + 8) @(posedge i_clk);
    endtask

    task write_defaults(logic [23:0] f, logic [23:0] b);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CfgDefFg;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_idx <= CfgDefBg;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_default(CfgDefFg, f);
        sb.set_default(CfgDefBg, b);
    endtask

    function automatic int pick_code();
        int codes[24] = '{0, 1, 2, 3, 4, 7, 9, 21, 22, 23, 24, 27, 29, 38, 48, 39, 49,
                          30, 37, 40, 47, 90, 100, 107};
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 999);
        return codes[$urandom_range(0, 23)];
    endfunction

    task automatic send_csi();
        string finals = "ABCDEFGHfm";
        int n;
        int v;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 6);
        send_char(EscChar);
        send_char("[");
        for (int k = 0; k < n; k++) begin
            v = pick_code();
            if ($urandom_range(0, 9) == 0) send_char("0");
            send_text($sformatf("%0d", v));
            if (k < n - 1 || $urandom_range(0, 4) == 0) begin
                send_char(($urandom_range(0, 1) != 0) ? " " : ";");
                if ($urandom_range(0, 9) == 0) send_char(";");
            end
        end
        if ($urandom_range(0, 15) == 0) send_char(8'($urandom));
        else send_char(finals[$urandom_range(0, 9)]);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_defaults(24'h000000, 24'hFFFFFF);

        send_palette(4'd0, 24'hFFFFFF);
        send_palette(4'd15, 24'h123456);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(EscChar); send_char("x");
        send_text("\033[5A\033[B\033[300C\033[D\033[2E\033[F\033[7G");
        send_text("\033[3;4H\033[9f\033[q\033[\033");
        send_text("\033[1;3;4;9;7;31;42mQ\033[0;27;38;5;15;48;5;200mR");
        send_text("\033[38;2;1;2;3;48;5;250;2;21mS\033[38;9;22;23;24;29;38;2;1;2mT");
        send_text("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18;19m\033[99;97;107mU");
        send_text("\033[48;7;39;49;0mV");
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_defaults(24'hFFFFFF, 24'h000000);
                1: write_defaults(24'($urandom), 24'($urandom));
                2: write_defaults(24'h000000, 24'h000000);
                default: write_defaults(24'hFFFFFF, 24'hFFFFFF);
            endcase
            calm = (ph == 2);
            while (sent < (ph + 1) * RandomItems / 4) begin
                case ($urandom_range(0, 19))
                    0: send_palette(4'($urandom), 24'($urandom));
                    1: send_char(8'($urandom));
                    2: begin send_char(EscChar); send_char(8'($urandom)); end
                    3, 4, 5, 6, 7, 8, 9, 10: send_csi();
                    default: send_char(8'($urandom_range(32, 126)));
                endcase
            end
            drain();
        end

        $display("Sent %0d requests, checked %0d results across 5 default-colour settings",
                 sent, sb.matched);
        $display("Covered cursor finals, SGR attribute and colour codes, palette writes");
        if (sb.errors == 0 && sb.glyph_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
